// ===== rtl/fbm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fbm_pkg;

    // Default geometry of the bitmap
    localparam int BITMAP_WORDS_DEF  = 16;
    localparam int BITS_PER_WORD_DEF = 32;

    // Request and result field widths
    localparam int OP_W          = 3;
    localparam int FRAME_IN_W    = 9;
    localparam int RES_FRAME_W   = 9;
    localparam int S_TDATA_W     = 16;
    localparam int M_TDATA_W     = 16;

    // Operation codes
    localparam logic [OP_W-1:0] OP_CLEAR_ALL = 3'd0;
    localparam logic [OP_W-1:0] OP_MARK_USED = 3'd1;
    localparam logic [OP_W-1:0] OP_MARK_FREE = 3'd2;
    localparam logic [OP_W-1:0] OP_FIND      = 3'd3;
    localparam logic [OP_W-1:0] OP_ALLOC     = 3'd4;

endpackage

`default_nettype wire

// ===== rtl/fbm_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fbm_store #(
    parameter int BITMAP_WORDS  = fbm_pkg::BITMAP_WORDS_DEF,
    parameter int BITS_PER_WORD = fbm_pkg::BITS_PER_WORD_DEF,
    parameter int ADDR_W        = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_clr,
    input  wire logic                     i_wr_en,
    input  wire logic [ADDR_W-1:0]        i_wr_addr,
    input  wire logic [BITS_PER_WORD-1:0] i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [ADDR_W-1:0]        i_rd_addr,
    output logic [BITS_PER_WORD-1:0]      o_rd_data
);

    // Bitmap words; contents only meaningful where the valid bit is set
    logic [BITS_PER_WORD-1:0] r_mem [BITMAP_WORDS];
    logic [BITMAP_WORDS-1:0]  r_valid;
    logic [BITS_PER_WORD-1:0] r_rd_data;
    logic                     r_rd_valid;

    // Per-word valid bits: reset and clear-all free every frame at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    // A word never written since the last clear reads as all free
    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

`default_nettype wire

// ===== rtl/frame_bitmap_allocator.sv =====
// Clear all and unused ops go straight to the result word; mark used/free splits the
// frame (word index by reciprocal multiply) and rewrites that word, or ends there when
// the frame lies beyond the bitmap; find reads one bitmap word per cycle through the
// single read port up to the first hit; allocate adds a write back. One request at a
// time: the next is taken the cycle after the result is queued, later while a held word
// waits. Synchronous active-low reset frees every frame and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module frame_bitmap_allocator #(
    parameter int BITMAP_WORDS  = fbm_pkg::BITMAP_WORDS_DEF,
    parameter int BITS_PER_WORD = fbm_pkg::BITS_PER_WORD_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // request: [2:0] op, [11:3] frame_number, [15:12] zero
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [fbm_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // result: [0] found, [9:1] result_frame, [15:10] zero
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [fbm_pkg::M_TDATA_W-1:0]       m_axis_tdata
);

    localparam int ADDR_W = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int CNT_W  = $clog2(BITMAP_WORDS + 1);
    localparam int BIT_W  = $clog2(BITS_PER_WORD);
    localparam int FULL_W = $clog2(BITMAP_WORDS * BITS_PER_WORD);
    localparam int FR_W   = (FULL_W > fbm_pkg::RES_FRAME_W) ? FULL_W : fbm_pkg::RES_FRAME_W;
    localparam int OP_W   = fbm_pkg::OP_W;
    localparam int FIN_W  = fbm_pkg::FRAME_IN_W;

    // frame / BITS_PER_WORD as (frame * DIV_RCP) >> DIV_SH, exact over FIN_W-bit frames
    localparam int DIV_SH  = FIN_W + BIT_W;
    localparam int DIV_RCP = ((1 << DIV_SH) + BITS_PER_WORD - 1) / BITS_PER_WORD;
    localparam int PROD_W  = 2 * FIN_W + 2;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_MOD  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_WR   = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    // Lowest clear bit of a word
    function automatic logic [BIT_W-1:0] f_low_zero(input logic [BITS_PER_WORD-1:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = BITS_PER_WORD - 1; i >= 0; i--) begin
            if (!v[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

    logic [2:0]               r_state, n_state;
    logic [OP_W-1:0]          r_op, n_op;
    logic [FIN_W-1:0]         r_rem, n_rem;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic                     r_chk_vld, n_chk_vld;
    logic [ADDR_W-1:0]        r_chk_addr, n_chk_addr;
    logic [BITS_PER_WORD-1:0] r_hit_word, n_hit_word;
    logic                     r_found, n_found;
    logic [FR_W-1:0]          r_frame, n_frame;
    logic                     r_out_vld, n_out_vld;
    logic                     r_out_found, n_out_found;
    logic [fbm_pkg::RES_FRAME_W-1:0] r_out_frame, n_out_frame;

    logic                     accept;
    logic                     st_clr;
    logic                     st_wr_en;
    logic [ADDR_W-1:0]        st_wr_addr;
    logic [BITS_PER_WORD-1:0] st_wr_data;
    logic                     st_rd_en;
    logic [ADDR_W-1:0]        st_rd_addr;
    logic [BITS_PER_WORD-1:0] st_rd_data;
    logic [BIT_W-1:0]         hit_bit;
    logic [BITS_PER_WORD-1:0] rem_mask;
    logic [BITS_PER_WORD-1:0] hit_mask;
    logic                     scan_issue;
    logic [PROD_W-1:0]        div_prod;
    logic [FIN_W-1:0]         div_q;
    logic [FIN_W-1:0]         div_r;
    logic                     div_ok;

    fbm_store #(
        .BITMAP_WORDS  (BITMAP_WORDS),
        .BITS_PER_WORD (BITS_PER_WORD),
        .ADDR_W        (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (st_clr),
        .i_wr_en   (st_wr_en),
        .i_wr_addr (st_wr_addr),
        .i_wr_data (st_wr_data),
        .i_rd_en   (st_rd_en),
        .i_rd_addr (st_rd_addr),
        .o_rd_data (st_rd_data)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign hit_bit       = f_low_zero(st_rd_data);
    assign hit_mask      = BITS_PER_WORD'(1) << hit_bit;
    assign rem_mask      = BITS_PER_WORD'(1) << r_rem[BIT_W-1:0];
    assign scan_issue    = (r_cnt < CNT_W'(BITMAP_WORDS));

    // Word index and bit offset of the requested frame
    assign div_prod = PROD_W'(r_rem) * PROD_W'(DIV_RCP);
    assign div_q    = FIN_W'(div_prod >> DIV_SH);
    assign div_r    = r_rem - div_q * FIN_W'(BITS_PER_WORD);
    assign div_ok   = (int'(div_q) < BITMAP_WORDS);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_chk_vld   = r_chk_vld;
        n_chk_addr  = r_chk_addr;
        n_hit_word  = r_hit_word;
        n_found     = r_found;
        n_frame     = r_frame;
        n_out_vld   = r_out_vld && !m_axis_tready;
        n_out_found = r_out_found;
        n_out_frame = r_out_frame;
        st_clr      = 1'b0;
        st_wr_en    = 1'b0;
        st_wr_addr  = r_cnt[ADDR_W-1:0];
        st_wr_data  = '0;
        st_rd_en    = 1'b0;
        st_rd_addr  = r_cnt[ADDR_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op      = s_axis_tdata[OP_W-1:0];
                    n_rem     = s_axis_tdata[OP_W +: FIN_W];
                    n_cnt     = '0;
                    n_chk_vld = 1'b0;
                    n_found   = 1'b0;
                    n_frame   = '0;
                    unique case (s_axis_tdata[OP_W-1:0])
                        fbm_pkg::OP_CLEAR_ALL: begin
                            st_clr  = 1'b1;
                            n_state = S_DONE;
                        end
                        fbm_pkg::OP_MARK_USED,
                        fbm_pkg::OP_MARK_FREE: n_state = S_DIV;
                        fbm_pkg::OP_FIND,
                        fbm_pkg::OP_ALLOC:     n_state = S_SCAN;
                        default:               n_state = S_DONE;
                    endcase
                end
            end
            // split the frame into word and bit, read the word if it exists
            S_DIV: begin
                if (!div_ok) begin
                    n_state = S_DONE;
                end else begin
                    st_rd_en   = 1'b1;
                    st_rd_addr = ADDR_W'(div_q);
                    n_cnt      = CNT_W'(div_q);
                    n_rem      = div_r;
                    n_state    = S_MOD;
                end
            end
            // read-modify-write of one bit
            S_MOD: begin
                st_wr_en   = 1'b1;
                st_wr_data = (r_op == fbm_pkg::OP_MARK_USED) ? (st_rd_data | rem_mask)
                                                             : (st_rd_data & ~rem_mask);
                n_state    = S_DONE;
            end
            // one word read per cycle, previous word checked in the same cycle
            S_SCAN: begin
                st_rd_en   = scan_issue;
                n_chk_vld  = scan_issue;
                n_chk_addr = r_cnt[ADDR_W-1:0];
                if (scan_issue) begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
                if (r_chk_vld && !(&st_rd_data)) begin
                    n_found    = 1'b1;
                    n_chk_addr = r_chk_addr;
                    n_frame    = FR_W'(r_chk_addr) * FR_W'(BITS_PER_WORD) + FR_W'(hit_bit);
                    n_hit_word = st_rd_data | hit_mask;
                    n_state    = (r_op == fbm_pkg::OP_ALLOC) ? S_WR : S_DONE;
                end else if (r_chk_vld && !scan_issue) begin
                    n_state = S_DONE;
                end
            end
            S_WR: begin
                st_wr_en   = 1'b1;
                st_wr_addr = r_chk_addr;
                st_wr_data = r_hit_word;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (!r_out_vld || m_axis_tready) begin
                    n_out_vld   = 1'b1;
                    n_out_found = r_found;
                    n_out_frame = r_frame[fbm_pkg::RES_FRAME_W-1:0];
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_chk_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_chk_vld <= n_chk_vld;
        end
    end

    // Working and result registers
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_rem       <= n_rem;
        r_cnt       <= n_cnt;
        r_chk_addr  <= n_chk_addr;
        r_hit_word  <= n_hit_word;
        r_found     <= n_found;
        r_frame     <= n_frame;
        r_out_found <= n_out_found;
        r_out_frame <= n_out_frame;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{(fbm_pkg::M_TDATA_W - fbm_pkg::RES_FRAME_W - 1){1'b0}},
                            r_out_frame, r_out_found};

`ifndef SYNTH
    // a taken request blocks the input until its result is queued
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !s_axis_tready)
        else $error("input ready right after accepting a request");

    // a miss always reports frame zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !r_out_found) |-> (r_out_frame == '0))
        else $error("result without a hit carries a nonzero frame");

    // the bit update uses a remainder below the word size
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD) |-> (r_rem < FIN_W'(BITS_PER_WORD)))
        else $error("bit index beyond word size");

    // the scan never runs past the last word
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_cnt <= CNT_W'(BITMAP_WORDS)))
        else $error("scan address beyond bitmap");

    // an allocate writes back exactly once after a hit
    a_alloc_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |-> (r_found && $past(r_state) == S_SCAN))
        else $error("write back without a preceding hit");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_frame_bitmap_allocator.sv =====
`timescale 1ns / 1ps

module tb_frame_bitmap_allocator;

    localparam int OP_W         = fbm_pkg::OP_W;
    localparam int FRAME_IN_W   = fbm_pkg::FRAME_IN_W;
    localparam int RES_FRAME_W  = fbm_pkg::RES_FRAME_W;
    localparam int S_TDATA_W    = fbm_pkg::S_TDATA_W;
    localparam int M_TDATA_W    = fbm_pkg::M_TDATA_W;
    localparam int N_WORDS      = fbm_pkg::BITMAP_WORDS_DEF;
    localparam int WORD_BITS    = fbm_pkg::BITS_PER_WORD_DEF;
    localparam int N_FRAMES     = N_WORDS * WORD_BITS;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;

    // Op codes the block does not define
    localparam logic [OP_W-1:0] OP_UNUSED_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

    localparam bit CHK  = 1'b1;   // row carries its own expected word
    localparam bit PRED = 1'b0;   // row is checked against the predictor

    typedef struct packed {
        logic                   found;
        logic [RES_FRAME_W-1:0] frame;
    } t_alloc_result;

    typedef struct packed {
        logic [OP_W-1:0]        op;
        logic [FRAME_IN_W-1:0]  frame;
        logic                   typed;
        logic                   exp_found;
        logic [RES_FRAME_W-1:0] exp_frame;
    } t_request_row;

    typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_SPARSE} t_sink_mode;

    // Directed requests, starting from an all-free bitmap
    localparam int N_DIRECTED = 24;
    localparam t_request_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{fbm_pkg::OP_FIND,      9'd0,   CHK,  1'b1, 9'd0},
        '{fbm_pkg::OP_ALLOC,     9'd0,   CHK,  1'b1, 9'd0},
        '{fbm_pkg::OP_ALLOC,     9'd0,   CHK,  1'b1, 9'd1},
        '{fbm_pkg::OP_FIND,      9'd511, CHK,  1'b1, 9'd2},
        '{fbm_pkg::OP_MARK_USED, 9'd2,   CHK,  1'b0, 9'd0},
        '{fbm_pkg::OP_MARK_USED, 9'd511, CHK,  1'b0, 9'd0},
        '{fbm_pkg::OP_FIND,      9'd0,   PRED, 1'b0, 9'd0},
        '{fbm_pkg::OP_MARK_FREE, 9'd0,   CHK,  1'b0, 9'd0},
        '{fbm_pkg::OP_ALLOC,     9'd0,   PRED, 1'b0, 9'd0},
        '{fbm_pkg::OP_MARK_USED, 9'd31,  CHK,  1'b0, 9'd0},
        '{fbm_pkg::OP_MARK_USED, 9'd32,  CHK,  1'b0, 9'd0},
        '{fbm_pkg::OP_MARK_FREE, 9'd32,  CHK,  1'b0, 9'd0},
        '{OP_UNUSED_5,           9'd511, CHK,  1'b0, 9'd0},
        '{OP_UNUSED_6,           9'd0,   CHK,  1'b0, 9'd0},
        '{OP_UNUSED_7,           9'h0AA, CHK,  1'b0, 9'd0},
        '{fbm_pkg::OP_CLEAR_ALL, 9'd511, CHK,  1'b0, 9'd0},
        '{fbm_pkg::OP_FIND,      9'd0,   CHK,  1'b1, 9'd0},
        '{fbm_pkg::OP_MARK_USED, 9'd0,   CHK,  1'b0, 9'd0},
        '{fbm_pkg::OP_ALLOC,     9'h155, PRED, 1'b0, 9'd0},
        '{fbm_pkg::OP_MARK_FREE, 9'd511, CHK,  1'b0, 9'd0},
        '{fbm_pkg::OP_MARK_FREE, 9'd256, CHK,  1'b0, 9'd0},
        '{fbm_pkg::OP_FIND,      9'd0,   PRED, 1'b0, 9'd0},
        '{fbm_pkg::OP_CLEAR_ALL, 9'd0,   CHK,  1'b0, 9'd0},
        '{fbm_pkg::OP_ALLOC,     9'd0,   CHK,  1'b1, 9'd0}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // request: [2:0] op, [11:3] frame_number, [15:12] zero
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // result: [0] found, [9:1] result_frame, [15:10] zero
    logic [M_TDATA_W-1:0]  m_axis_tdata;

    // Predictor state: one bit per frame, 1 = used
    logic [WORD_BITS-1:0]  frame_map [N_WORDS];
    t_alloc_result         pending_results [$];
    int                    n_fail = 0;
    int                    cycle_count = 0;
    int                    burst_left = 0;
    t_sink_mode            sink_mode = SINK_OPEN;
    int                    sink_mode_left = 0;
    int unsigned           sink_tick = 0;

    frame_bitmap_allocator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic void mark_frame(input int frame, input bit used);
        int w;
        w = frame / WORD_BITS;
        if (w < N_WORDS)
            frame_map[w][frame % WORD_BITS] = used;
    endfunction

    // Applies one request to the shadow bitmap and returns the word it should produce
    function automatic t_alloc_result predict_request(input logic [OP_W-1:0] op,
                                                      input logic [FRAME_IN_W-1:0] frame);
        t_alloc_result res;
        bit            hit;
        res = '0;
        hit = 1'b0;
        case (op)
            fbm_pkg::OP_CLEAR_ALL: begin
                foreach (frame_map[i])
                    frame_map[i] = '0;
            end
            fbm_pkg::OP_MARK_USED: mark_frame(int'(frame), 1'b1);
            fbm_pkg::OP_MARK_FREE: mark_frame(int'(frame), 1'b0);
            fbm_pkg::OP_FIND, fbm_pkg::OP_ALLOC: begin
                // lowest free frame, word 0 bit 0 upward
                for (int w = 0; w < N_WORDS && !hit; w++) begin
                    for (int b = 0; b < WORD_BITS && !hit; b++) begin
                        if (!frame_map[w][b]) begin
                            hit       = 1'b1;
                            res.found = 1'b1;
                            res.frame = RES_FRAME_W'(w * WORD_BITS + b);
                        end
                    end
                end
                if (hit && op == fbm_pkg::OP_ALLOC)
                    mark_frame(int'(res.frame), 1'b1);
            end
            default: ;
        endcase
        return res;
    endfunction

    // Sender pacing: bursts of back-to-back words, then a random gap
    task automatic pace_sender();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= S_TDATA_W'($urandom);
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(0, 15);
            if ($urandom_range(3) == 0)
                burst_left += 40;
        end
    endtask

    task automatic send_request(input logic [OP_W-1:0] op, input logic [FRAME_IN_W-1:0] frame,
                                input bit typed, input t_alloc_result typed_res);
        t_alloc_result predicted;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W - OP_W - FRAME_IN_W){1'b0}}, frame, op};
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = predict_request(op, frame);
        pending_results.push_back(typed ? typed_res : predicted);
        pace_sender();
    endtask

    task automatic send_mixed(input int clear_pct);
        int              r;
        logic [OP_W-1:0] op;
        r = $urandom_range(99);
        if (r < clear_pct)
            op = fbm_pkg::OP_CLEAR_ALL;
        else if (r < 30)
            op = fbm_pkg::OP_ALLOC;
        else if (r < 52)
            op = fbm_pkg::OP_MARK_USED;
        else if (r < 74)
            op = fbm_pkg::OP_MARK_FREE;
        else if (r < 92)
            op = fbm_pkg::OP_FIND;
        else
            op = OP_W'($urandom_range(OP_UNUSED_5, OP_UNUSED_7));
        send_request(op, FRAME_IN_W'($urandom_range(N_FRAMES - 1)), PRED, '0);
    endtask

    // Receiver stalls: open, coin-flip, or one cycle in four, switching now and then
    always @(posedge i_clk) begin
        if (sink_mode_left == 0) begin
            sink_mode      <= t_sink_mode'($urandom_range(2));
            sink_mode_left <= $urandom_range(20, 200);
        end else begin
            sink_mode_left <= sink_mode_left - 1;
        end
        case (sink_mode)
            SINK_OPEN:   m_axis_tready <= 1'b1;
            SINK_RANDOM: m_axis_tready <= 1'($urandom_range(1));
            default:     m_axis_tready <= (sink_tick[1:0] == 2'd0);
        endcase
        sink_tick <= sink_tick + 1;
    end

    // Result checker
    always @(posedge i_clk) begin
        t_alloc_result exp_res;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result word 0x%04h", m_axis_tdata);
                n_fail++;
            end else begin
                exp_res = pending_results.pop_front();
                if (m_axis_tdata[0] !== exp_res.found) begin
                    $error("found: expected %0d, got %0d", exp_res.found, m_axis_tdata[0]);
                    n_fail++;
                end
                if (m_axis_tdata[RES_FRAME_W:1] !== exp_res.frame) begin
                    $error("result_frame: expected %0d, got %0d",
                           exp_res.frame, m_axis_tdata[RES_FRAME_W:1]);
                    n_fail++;
                end
                if (m_axis_tdata[M_TDATA_W-1:RES_FRAME_W+1] !== '0) begin
                    $error("pad: expected 0, got 0x%0h",
                           m_axis_tdata[M_TDATA_W-1:RES_FRAME_W+1]);
                    n_fail++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int n_alloc;
        foreach (frame_map[i])
            frame_map[i] = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows
        for (int i = 0; i < N_DIRECTED; i++) begin
            send_request(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].frame, DIRECTED_ROWS[i].typed,
                         {DIRECTED_ROWS[i].exp_found, DIRECTED_ROWS[i].exp_frame});
        end

        // random mix with frequent clears
        repeat (600) send_mixed(4);

        // fill the whole bitmap by allocation, then run past full
        send_request(fbm_pkg::OP_CLEAR_ALL, FRAME_IN_W'($urandom_range(N_FRAMES - 1)),
                     PRED, '0);
        n_alloc = 0;
        while (n_alloc < N_FRAMES + 4) begin
            if ($urandom_range(9) == 0) begin
                send_request(fbm_pkg::OP_FIND, FRAME_IN_W'($urandom), PRED, '0);
            end else begin
                send_request(fbm_pkg::OP_ALLOC, FRAME_IN_W'($urandom), PRED, '0);
                n_alloc++;
            end
        end

        // punch holes in a full map and take them back
        repeat (60) begin
            case ($urandom_range(3))
                0: send_request(fbm_pkg::OP_MARK_FREE,
                                FRAME_IN_W'($urandom_range(N_FRAMES - 1)), PRED, '0);
                1: send_request(fbm_pkg::OP_ALLOC, FRAME_IN_W'($urandom), PRED, '0);
                2: send_request(fbm_pkg::OP_FIND, FRAME_IN_W'($urandom), PRED, '0);
                default: send_request(fbm_pkg::OP_MARK_USED,
                                      FRAME_IN_W'($urandom_range(N_FRAMES - 1)), PRED, '0);
            endcase
        end

        // long random run, rare clears so the map gets dense
        repeat (650) send_mixed(1);

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_fail == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
